@@ sv/pssg_pkg.sv @@
// shared types, constants and threshold table for the poisson sample-sum generator
package pssg_pkg;

  // generator and table constants
  localparam int unsigned      FRAC         = 60;
  localparam int unsigned      SERIES_TERMS = 40;
  localparam int unsigned      TBL_LEN      = 63;
  localparam int unsigned      MAX_DRAW_DEF = 15;
  localparam logic [30:0]      MODULUS      = 31'h7FFF_FFFF;
  localparam logic [14:0]      PM_MULT      = 15'd16807;
  localparam logic [19:0]      SUM_LIMIT    = 20'hF_FFFF;
  localparam logic [30:0]      SEED_RESET   = 31'd1;
  localparam logic [15:0]      DRAWS_RESET  = 16'd100;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_SEED  = 1'b0,
    REG_DRAWS = 1'b1
  } cfg_reg_t;

  // commands from controller to datapath
  typedef struct packed {
    logic start;
    logic mul;
    logic red;
    logic out_load;
  } pssg_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last_draw;
    logic zero_count;
  } pssg_status_t;

  typedef logic [30:0] thr_tab_t [TBL_LEN];

  // thresholds floor(cdf(j) * modulus) from a 60-bit fixed-point cdf of poisson(2)
  function automatic thr_tab_t build_thr_tab();
    thr_tab_t    tab;
    logic [63:0] one;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] prob;
    logic [63:0] cdf;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] acc;
    logic [63:0] mod64;
    one   = 64'd1 << FRAC;
    mod64 = 64'(MODULUS);
    term  = one;
    pos   = one;
    neg   = 64'd0;
    // e^-2 as an alternating series with truncated terms
    for (int i = 1; i <= int'(SERIES_TERMS); i++) begin
      term = (term * 64'd2) / 64'(i);
      if ((i & 1) != 0) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    prob = (pos > neg) ? pos - neg : 64'd0;
    cdf  = 64'd0;
    for (int j = 0; j < int'(TBL_LEN); j++) begin
      cdf = cdf + prob;
      if (cdf > one) begin
        cdf = one;
      end
      hi     = cdf >> 30;
      lo     = cdf & ((64'd1 << 30) - 64'd1);
      acc    = mod64 * hi + ((mod64 * lo) >> 30);
      tab[j] = 31'(acc >> 30);
      prob   = (prob * 64'd2) / 64'(j + 1);
    end
    return tab;
  endfunction

  localparam thr_tab_t THR_TAB = build_thr_tab();

endpackage

@@ sv/pssg_ctrl.sv @@
// batch controller: sequences the draws of one batch and owns the result valid flag
module pssg_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_start,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pssg_pkg::pssg_cmd_t   cmd,
  input  pssg_pkg::pssg_status_t status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED,
    ST_HOLD
  } state_t;

  state_t state;
  logic   accept;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // commands follow the current state
  always_comb begin
    cmd          = '0;
    cmd.start    = accept && in_start;
    cmd.mul      = (state == ST_MUL);
    cmd.red      = (state == ST_RED);
    cmd.out_load = (state == ST_HOLD) && out_free;
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && in_start) begin
            state <= status.zero_count ? ST_HOLD : ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_RED;
        end
        ST_RED: begin
          state <= status.last_draw ? ST_HOLD : ST_MUL;
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/pssg_dp.sv @@
// datapath: park-miller generator, threshold search, saturating sum and result registers
module pssg_dp #(
  parameter int unsigned MaxDraw = pssg_pkg::MAX_DRAW_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   seed_load,
  input  logic [30:0]            seed_value,
  input  logic [15:0]            draws_per_result,
  input  pssg_pkg::pssg_cmd_t    cmd,
  output pssg_pkg::pssg_status_t status,
  output logic [19:0]            draw_sum,
  output logic [15:0]            draw_count
);

  localparam int unsigned DRAW_W = $clog2(MaxDraw + 1);

  logic [30:0]       z;
  logic [45:0]       prod;
  logic [DRAW_W-1:0] draw_q;
  logic [DRAW_W-1:0] draw_val;
  logic [19:0]       run_sum;
  logic [15:0]       done;
  logic [15:0]       n_q;
  logic [31:0]       fold;
  logic [30:0]       z_next;
  logic [20:0]       sum_ext;
  logic [19:0]       run_sum_next;
  logic [15:0]       done_next;

  // smallest index whose threshold covers z, else the top value
  always_comb begin
    draw_val = DRAW_W'(MaxDraw);
    for (int j = int'(MaxDraw) - 1; j >= 0; j--) begin
      if (z <= pssg_pkg::THR_TAB[j]) begin
        draw_val = DRAW_W'(j);
      end
    end
  end

  // mod 2^31-1 by folding the high part onto the low part
  always_comb begin
    fold   = 32'(prod[45:31]) + 32'(prod[30:0]);
    z_next = (fold >= 32'(pssg_pkg::MODULUS)) ? 31'(fold - 32'(pssg_pkg::MODULUS))
                                              : fold[30:0];
  end

  // saturating accumulate and draw counter
  always_comb begin
    sum_ext      = 21'(run_sum) + 21'(draw_q);
    run_sum_next = (sum_ext > 21'(pssg_pkg::SUM_LIMIT)) ? pssg_pkg::SUM_LIMIT
                                                          : sum_ext[19:0];
    done_next    = done + 16'd1;
  end

  assign status.last_draw  = (done_next == n_q);
  assign status.zero_count = (draws_per_result == 16'd0);

  // generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      z <= pssg_pkg::SEED_RESET;
    end else if (seed_load) begin
      z <= seed_value;
    end else if (cmd.red) begin
      z <= z_next;
    end
  end

  // batch registers
  always_ff @(posedge clk) begin
    if (rst) begin
      run_sum <= '0;
      done    <= '0;
      n_q     <= '0;
    end else if (cmd.start) begin
      run_sum <= '0;
      done    <= '0;
      n_q     <= draws_per_result;
    end else if (cmd.red) begin
      run_sum <= run_sum_next;
      done    <= done_next;
    end
  end

  // product and draw of the current state
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod   <= z * pssg_pkg::PM_MULT;
      draw_q <= draw_val;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      draw_sum   <= run_sum;
      draw_count <= n_q;
    end
  end

endmodule

@@ sv/poisson_sample_sum_generator.sv @@
// top level of the poisson sample-sum generator
//
//   channel   dir  handshake             contents
//   s_axis    in   tvalid/tready         start_batch
//   m_axis    out  tvalid/tready         draw_sum, draw_count
//   cfg       in   cfg_we (no wait)      seed_value, draws_per_result
//
// a batch of N draws is accepted, then runs a multiply step and a reduce step per
// draw on the single generator loop, then loads the result.
// a request with start_batch low is taken and gives no result.
// after reset the generator state is 1 and the draw count is 100; no clearing pass.
// a waiting result stalls only the end of the next batch, not its acceptance.
module poisson_sample_sum_generator #(
  parameter int unsigned MaxDraw = pssg_pkg::MAX_DRAW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] start_batch, [7:1] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [19:0] draw_sum, [35:20] draw_count, [39:36] zero
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  pssg_pkg::pssg_cmd_t    cmd;
  pssg_pkg::pssg_status_t status;
  logic [15:0]            draws_per_result;
  logic                   seed_load;
  logic [19:0]            draw_sum;
  logic [15:0]            draw_count;

  assign seed_load = cfg_we && (cfg_index == pssg_pkg::REG_SEED);

  // draw count register
  always_ff @(posedge clk) begin
    if (rst) begin
      draws_per_result <= pssg_pkg::DRAWS_RESET;
    end else if (cfg_we && (cfg_index == pssg_pkg::REG_DRAWS)) begin
      draws_per_result <= cfg_data[15:0];
    end
  end

  pssg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_start  (s_axis_tdata[0]),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

  pssg_dp #(
    .MaxDraw (MaxDraw)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .seed_load        (seed_load),
    .seed_value       (cfg_data),
    .draws_per_result (draws_per_result),
    .cmd              (cmd),
    .status           (status),
    .draw_sum         (draw_sum),
    .draw_count       (draw_count)
  );

  assign m_axis_tdata = {4'd0, draw_count, draw_sum};

endmodule

@@ test/testbench.sv @@
// self-checking testbench for the poisson sample-sum generator
module testbench;

  localparam int unsigned THR_FRAC   = 60;
  localparam int unsigned SERIES_LEN = 40;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  typedef struct {
    logic [19:0] sum;
    logic [15:0] count;
  } batch_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [0] start_batch, [7:1] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [19:0] draw_sum, [35:20] draw_count, [39:36] zero
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [30:0] cfg_data;

  // predictor state and thresholds
  longint unsigned cdf_thr [pssg_pkg::TBL_LEN];
  logic [30:0]     gen_state;
  logic [15:0]     batch_len;

  // request stream and expected batch sums
  bit              request_q [$];
  batch_result_t   expected_sums [$];
  bit              in_taken;
  int unsigned     src_idle_pct;
  int unsigned     dst_idle_pct;

  int unsigned     fail_cnt;
  int unsigned     batches_sent;
  int unsigned     batches_checked;
  int unsigned     idle_requests;
  int unsigned     reg_writes;
  int unsigned     cycle_cnt;

  poisson_sample_sum_generator u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // thresholds floor(cdf(j) * modulus), cdf in 60-bit fixed point
  function automatic void fill_thresholds();
    longint unsigned unit_val;
    longint unsigned t;
    longint unsigned even_sum;
    longint unsigned odd_sum;
    longint unsigned p;
    longint unsigned c;
    logic [127:0]    prod;
    int              k;
    unit_val = 64'd1 << THR_FRAC;
    t        = unit_val;
    even_sum = unit_val;
    odd_sum  = 64'd0;
    // e^-2 from the truncated alternating series
    for (k = 1; k <= int'(SERIES_LEN); k++) begin
      t = (t * 64'd2) / 64'(k);
      if (k % 2 == 1) begin
        odd_sum += t;
      end else begin
        even_sum += t;
      end
    end
    p = (even_sum > odd_sum) ? even_sum - odd_sum : 64'd0;
    c = 64'd0;
    for (k = 0; k < int'(pssg_pkg::TBL_LEN); k++) begin
      c += p;
      if (c > unit_val) begin
        c = unit_val;
      end
      prod       = 128'(c) * 128'(pssg_pkg::MODULUS);
      cdf_thr[k] = 64'(prod >> THR_FRAC);
      p          = (p * 64'd2) / 64'(k + 1);
    end
  endfunction

  // smallest j whose threshold covers z, else the top value
  function automatic int unsigned poisson_draw(logic [30:0] z);
    int unsigned j;
    for (j = 0; j < pssg_pkg::MAX_DRAW_DEF && j < pssg_pkg::TBL_LEN; j++) begin
      if (64'(z) <= cdf_thr[j]) begin
        return j;
      end
    end
    return pssg_pkg::MAX_DRAW_DEF;
  endfunction

  // one whole batch: draws summed with saturation, generator advanced per draw
  function automatic batch_result_t predict_batch_sum();
    batch_result_t r;
    int unsigned   acc;
    int unsigned   k;
    acc = 0;
    for (k = 0; k < batch_len; k++) begin
      acc += poisson_draw(gen_state);
      if (acc > pssg_pkg::SUM_LIMIT) begin
        acc = pssg_pkg::SUM_LIMIT;
      end
      gen_state = 31'((64'(pssg_pkg::PM_MULT) * 64'(gen_state)) % 64'(pssg_pkg::MODULUS));
    end
    r.sum   = 20'(acc);
    r.count = batch_len;
    return r;
  endfunction

  function automatic void report_mismatch(string what);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("%s", what);
    end
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // timeout
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // driver: request transfers and receiver stalls, changed on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || in_taken) begin
        if (request_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tdata  <= {7'd0, request_q.pop_front()};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // monitor: register writes, accepted requests and result transfers
  always @(posedge clk) begin : monitor
    batch_result_t want;
    if (rst) begin
      gen_state = pssg_pkg::SEED_RESET;
      batch_len = pssg_pkg::DRAWS_RESET;
      in_taken  = 1'b0;
    end else begin
      in_taken = s_axis_tvalid && s_axis_tready;
      if (cfg_we) begin
        case (pssg_pkg::cfg_reg_t'(cfg_index))
          pssg_pkg::REG_SEED:  gen_state = cfg_data;
          pssg_pkg::REG_DRAWS: batch_len = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_taken) begin
        if (s_axis_tdata[0]) begin
          expected_sums.push_back(predict_batch_sum());
          batches_sent++;
        end else begin
          idle_requests++;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_sums.size() == 0) begin
          report_mismatch($sformatf("unexpected result sum=%0d count=%0d",
                                    m_axis_tdata[19:0], m_axis_tdata[35:20]));
        end else begin
          want = expected_sums.pop_front();
          batches_checked++;
          if (m_axis_tdata[19:0] !== want.sum || m_axis_tdata[35:20] !== want.count ||
              m_axis_tdata[39:36] !== 4'd0) begin
            report_mismatch($sformatf(
              "result %0d: expected sum=%0d count=%0d, got sum=%0d count=%0d pad=%0h",
              batches_checked, want.sum, want.count, m_axis_tdata[19:0],
              m_axis_tdata[35:20], m_axis_tdata[39:36]));
          end
        end
      end
    end
  end

  // wait until every request is taken and every batch sum has come back
  task automatic drain();
    @(posedge clk);
    while (request_q.size() != 0 || s_axis_tvalid || expected_sums.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(pssg_pkg::cfg_reg_t idx, logic [30:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    reg_writes++;
  endtask

  // random batches in chunks, with new settings between chunks
  task automatic random_phase(int unsigned n_batches);
    int unsigned done;
    int unsigned chunk;
    int unsigned pick;
    int unsigned k;
    logic [30:0] seed;
    logic [15:0] len;
    bit          big;
    done = 0;
    while (done < n_batches) begin
      drain();
      pick = $urandom_range(99);
      big  = 1'b0;
      if (pick < 5) begin
        len = 16'd0;
      end else if (pick < 8) begin
        len = 16'($urandom_range(4000, 1000));
        big = 1'b1;
      end else begin
        len = 16'($urandom_range(150, 1));
      end
      if ($urandom_range(99) < 70 || big) begin
        set_reg(pssg_pkg::REG_DRAWS, {15'd0, len});
      end
      if ($urandom_range(99) < 60) begin
        pick = $urandom_range(99);
        if (pick < 2) begin
          seed = 31'd0;
        end else if (pick < 4) begin
          seed = pssg_pkg::MODULUS;
        end else begin
          seed = 31'($urandom_range(2147483646, 1));
        end
        set_reg(pssg_pkg::REG_SEED, seed);
      end
      chunk = big ? 1 : $urandom_range(60, 10);
      for (k = 0; k < chunk; k++) begin
        if ($urandom_range(9) == 0) begin
          request_q.push_back(1'b0);
        end
        request_q.push_back(1'b1);
      end
      done += chunk;
    end
  endtask

  // stimulus
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    m_axis_tready = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = pssg_pkg::REG_SEED;
    cfg_data      = 31'd0;
    in_taken      = 1'b0;
    fail_cnt        = 0;
    batches_sent    = 0;
    batches_checked = 0;
    idle_requests   = 0;
    reg_writes      = 0;
    src_idle_pct  = 29;
    dst_idle_pct  = 87;
    fill_thresholds();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings, with an ignored request in between
    request_q.push_back(1'b1);
    request_q.push_back(1'b0);
    request_q.push_back(1'b1);
    drain();
    // seed zero keeps every draw at zero
    set_reg(pssg_pkg::REG_SEED, 31'd0);
    set_reg(pssg_pkg::REG_DRAWS, 31'd5);
    request_q.push_back(1'b1);
    drain();
    // seed at the modulus: top draw first, then the state sticks at zero
    set_reg(pssg_pkg::REG_SEED, pssg_pkg::MODULUS);
    set_reg(pssg_pkg::REG_DRAWS, 31'd3);
    request_q.push_back(1'b1);
    drain();
    // zero draw count
    set_reg(pssg_pkg::REG_DRAWS, 31'd0);
    request_q.push_back(1'b1);
    request_q.push_back(1'b0);
    drain();
    // largest seed and largest count
    set_reg(pssg_pkg::REG_SEED, 31'd2147483646);
    set_reg(pssg_pkg::REG_DRAWS, 31'd65535);
    request_q.push_back(1'b1);
    drain();
    // single draws, state carried across batches
    set_reg(pssg_pkg::REG_SEED, 31'd1);
    set_reg(pssg_pkg::REG_DRAWS, 31'd1);
    request_q.push_back(1'b1);
    request_q.push_back(1'b1);
    request_q.push_back(1'b1);
    request_q.push_back(1'b0);
    drain();
    set_reg(pssg_pkg::REG_SEED, 31'h2AAA_AAAA);
    set_reg(pssg_pkg::REG_DRAWS, 31'd150);
    request_q.push_back(1'b1);
    request_q.push_back(1'b1);

    random_phase(450);
    drain();
    src_idle_pct = 87;
    dst_idle_pct = 29;
    random_phase(450);
    drain();
    src_idle_pct = 0;
    dst_idle_pct = 0;
    random_phase(450);
    drain();
    repeat (20) @(posedge clk);

    if (expected_sums.size() != 0) begin
      report_mismatch($sformatf("%0d batch sums never arrived", expected_sums.size()));
    end
    $display("checked %0d of %0d batches, %0d idle requests, %0d register writes",
             batches_checked, batches_sent, idle_requests, reg_writes);
    $display("seeds zero and at the modulus, draw counts from 0 to 65535, %0d failures",
             fail_cnt);
    if (fail_cnt == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
